>>> src/mtpm_pkg.sv
`default_nettype none

package mtpm_pkg;

    // Fixed field widths.
    localparam int NUM_NOTES     = 128;
    localparam int NOTE_W        = $clog2(NUM_NOTES);
    localparam int NUM_CHANNELS  = 16;
    localparam int CHAN_W        = 4;
    localparam int ACTION_W      = 2;
    localparam int SCALE_W       = 24;
    localparam int MAPDEG_W      = 8;
    localparam int BEND_W        = 22;
    localparam int PITCH_W       = 31;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 8;

    // Default table depths.
    localparam int SCALE_DEPTH_DEF = 128;
    localparam int MAP_DEPTH_DEF   = 128;

    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Pitch constants in cents, Q8.
    localparam int CENTS_PER_SEMI_Q8 = 25600;
    localparam int OCTAVE_Q8         = 307200;

    // Input actions.
    localparam logic [ACTION_W-1:0] ACT_SCALE_WR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_MAP_WR   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TUNE     = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_RELEASE  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_NOTE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_OCTAVE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_LEN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_MAPPING    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_LEN        = 3'd4;

    // Kind of work the back part carries out for one queued beat.
    typedef enum logic [1:0] {
        K_SCALE_WR,
        K_MAP_WR,
        K_NOTE
    } t_kind;

    typedef struct packed {
        t_kind                     kind;
        logic                      apply;
        logic [CHAN_W-1:0]         channel;
        logic [NOTE_W-1:0]         note;
        logic signed [SCALE_W-1:0] wdata;
        logic signed [BEND_W-1:0]  bend;
    } t_qent;

endpackage

`default_nettype wire

>>> src/mtpm_front.sv
`default_nettype none

module mtpm_front #(
    parameter int SCALE_DEPTH = mtpm_pkg::SCALE_DEPTH_DEF,
    parameter int MAP_DEPTH   = mtpm_pkg::MAP_DEPTH_DEF
) (
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [mtpm_pkg::ACTION_W-1:0]         i_action,
    input  wire logic [mtpm_pkg::CHAN_W-1:0]           i_channel,
    input  wire logic [mtpm_pkg::NOTE_W-1:0]           i_note,
    input  wire logic signed [mtpm_pkg::SCALE_W-1:0]   i_scale_cents,
    input  wire logic signed [mtpm_pkg::MAPDEG_W-1:0]  i_map_degree,
    input  wire logic signed [mtpm_pkg::BEND_W-1:0]    i_bend_cents,
    input  wire logic                                  i_q_full,
    output logic                                       o_push,
    output mtpm_pkg::t_qent                            o_entry
);

    logic keep;

    // Beats that would change nothing (writes past a table, notes on a
    // channel that is not served) are taken and dropped here.
    always_comb begin
        keep            = 1'b0;
        o_entry.kind    = mtpm_pkg::K_NOTE;
        o_entry.apply   = (i_action == mtpm_pkg::ACT_TUNE);
        o_entry.channel = i_channel;
        o_entry.note    = i_note;
        o_entry.wdata   = i_scale_cents;
        o_entry.bend    = i_bend_cents;
        case (i_action)
            mtpm_pkg::ACT_SCALE_WR: begin
                o_entry.kind = mtpm_pkg::K_SCALE_WR;
                keep         = (32'(i_note) < 32'(SCALE_DEPTH));
            end
            mtpm_pkg::ACT_MAP_WR: begin
                o_entry.kind  = mtpm_pkg::K_MAP_WR;
                o_entry.wdata = mtpm_pkg::SCALE_W'(i_map_degree);
                keep          = (32'(i_note) < 32'(MAP_DEPTH));
            end
            mtpm_pkg::ACT_TUNE, mtpm_pkg::ACT_RELEASE: begin
                keep = (32'(i_channel) < 32'(mtpm_pkg::NUM_CHANNELS));
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full && keep;

endmodule

`default_nettype wire

>>> src/mtpm_queue.sv
`default_nettype none

module mtpm_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire mtpm_pkg::t_qent i_entry,
    output logic                 o_full,
    input  wire logic            i_pop,
    output mtpm_pkg::t_qent      o_entry,
    output logic                 o_empty
);

    localparam int PTR_W = (mtpm_pkg::QUEUE_DEPTH > 1) ? $clog2(mtpm_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(mtpm_pkg::QUEUE_DEPTH + 1);

    mtpm_pkg::t_qent   r_mem [mtpm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (32'(p) == mtpm_pkg::QUEUE_DEPTH - 1) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign o_full  = (32'(r_count) == mtpm_pkg::QUEUE_DEPTH);
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> src/mtpm_back.sv
`default_nettype none

module mtpm_back #(
    parameter int SCALE_DEPTH = mtpm_pkg::SCALE_DEPTH_DEF,
    parameter int MAP_DEPTH   = mtpm_pkg::MAP_DEPTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [mtpm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [mtpm_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire logic                                   i_q_empty,
    input  wire mtpm_pkg::t_qent                        i_q_entry,
    output logic                                        o_q_pop,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic [mtpm_pkg::CHAN_W-1:0]                 o_out_channel,
    output logic [mtpm_pkg::NOTE_W-1:0]                 o_out_note,
    output logic signed [mtpm_pkg::PITCH_W-1:0]         o_pitch_cents,
    output logic                                        o_apply_now
);

    localparam int SAW    = (SCALE_DEPTH > 1) ? $clog2(SCALE_DEPTH) : 1;
    localparam int MAW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int NW     = mtpm_pkg::NOTE_W;
    localparam int SW     = mtpm_pkg::SCALE_W;
    localparam int DW     = mtpm_pkg::MAPDEG_W;
    localparam int OCT_W  = DW + 1;
    localparam int PROD_W = OCT_W + SW;
    localparam int REFQ_W = 22;
    localparam int BASE_W = SW + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int PW     = mtpm_pkg::PITCH_W;

    localparam logic signed [SW-1:0] PERIOD_OCT  = SW'(mtpm_pkg::OCTAVE_Q8);
    localparam logic signed [SW-1:0] PERIOD_SEMI = SW'(mtpm_pkg::CENTS_PER_SEMI_Q8);
    localparam logic signed [PW-1:0] PITCH_MAX   = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] PITCH_MIN   = {1'b1, {(PW-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEG,
        S_DIV,
        S_FIX,
        S_MUL,
        S_SUM
    } t_state;

    // Configuration registers.
    logic [NW-1:0]  r_ref;
    logic           r_force;
    logic [7:0]     r_scale_len;
    logic           r_use_map;
    logic [7:0]     r_map_len;

    // Tables.
    logic signed [SW-1:0] r_scale_mem [SCALE_DEPTH];
    logic signed [DW-1:0] r_map_mem   [MAP_DEPTH];
    logic signed [SW-1:0] r_sc_rd;
    logic signed [DW-1:0] r_map_rd;

    // Item being worked on.
    t_state                   r_state;
    logic [mtpm_pkg::CHAN_W-1:0] r_channel;
    logic [NW-1:0]            r_note;
    logic                     r_apply;
    logic signed [mtpm_pkg::BEND_W-1:0] r_bend;
    logic signed [DW-1:0]     r_offset;
    logic                     r_hit;
    logic [7:0]               r_size;
    logic                     r_neg;
    logic [7:0]               r_quo;
    logic [7:0]               r_rem;
    logic [2:0]               r_cnt;
    logic signed [OCT_W-1:0]  r_oct;
    logic signed [SW-1:0]     r_period;
    logic                     r_idx_nz;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [BASE_W-1:0] r_base;

    // Lookup and arithmetic terms.
    logic signed [DW-1:0]     offset;
    logic                     map_hit;
    logic [MAW+NW-1:0]        map_ext;
    logic [MAW+NW-1:0]        map_wr_ext;
    logic [SAW+NW-1:0]        sc_wr_ext;
    logic [7:0]               size_clamp;
    logic signed [DW-1:0]     degree;
    logic [7:0]               deg_mag;
    logic [8:0]               div_shift;
    logic                     div_ge;
    logic signed [OCT_W-1:0]  q_signed;
    logic signed [OCT_W-1:0]  fix_oct;
    logic [7:0]               fix_idx;
    logic [7:0]               sc_rd_idx;
    logic [SAW+7:0]           sc_rd_ext;
    logic                     sc_rd_en;
    logic                     map_rd_en;
    logic                     sc_we;
    logic                     map_we;
    logic signed [PROD_W-1:0] prod;
    logic [REFQ_W-1:0]        ref_q8;
    logic signed [BASE_W-1:0] deg_term;
    logic signed [SUM_W-1:0]  bend_term;
    logic signed [SUM_W-1:0]  sum;
    logic signed [PW-1:0]     pitch_sat;
    logic                     out_free;

    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;
    assign sc_we   = o_q_pop && (i_q_entry.kind == mtpm_pkg::K_SCALE_WR);
    assign map_we  = o_q_pop && (i_q_entry.kind == mtpm_pkg::K_MAP_WR);

    // Key offset from the reference note and whether the mapping covers it.
    assign offset  = $signed({1'b0, i_q_entry.note}) - $signed({1'b0, r_ref});
    assign map_hit = r_use_map && (r_map_len != 8'd0) && !offset[DW-1]
                     && ({1'b0, offset[NW-1:0]} < r_map_len)
                     && (32'(offset[NW-1:0]) < 32'(MAP_DEPTH));
    assign map_ext    = {{MAW{1'b0}}, offset[NW-1:0]};
    assign map_wr_ext = {{MAW{1'b0}}, i_q_entry.note};
    assign sc_wr_ext  = {{SAW{1'b0}}, i_q_entry.note};
    assign map_rd_en  = o_q_pop && (i_q_entry.kind == mtpm_pkg::K_NOTE) && map_hit;

    assign size_clamp = (32'(r_scale_len) > 32'(SCALE_DEPTH)) ? 8'(SCALE_DEPTH)
                                                               : r_scale_len;
    assign degree  = r_hit ? r_map_rd : r_offset;
    assign deg_mag = degree[DW-1] ? 8'(-degree) : 8'(degree);

    // One restoring division step per cycle.
    assign div_shift = {r_rem, r_quo[7]};
    assign div_ge    = (div_shift >= {1'b0, r_size});

    // Turn the truncated quotient into a floored one.
    assign q_signed = $signed({1'b0, r_quo});
    always_comb begin
        if (!r_neg) begin
            fix_oct = q_signed;
            fix_idx = r_rem;
        end else if (r_rem == 8'd0) begin
            fix_oct = -q_signed;
            fix_idx = 8'd0;
        end else begin
            fix_oct = -q_signed - OCT_W'(1);
            fix_idx = r_size - r_rem;
        end
    end

    // The single scale read port serves the period entry, then the degree entry.
    assign sc_rd_idx = (r_state == S_DEG) ? (size_clamp - 8'd1) : (fix_idx - 8'd1);
    assign sc_rd_ext = {{SAW{1'b0}}, sc_rd_idx};
    assign sc_rd_en  = ((r_state == S_DEG) && (r_scale_len != 8'd0) && !r_force)
                       || ((r_state == S_FIX) && (fix_idx != 8'd0));

    assign prod     = r_oct * r_period;
    assign ref_q8   = REFQ_W'(r_ref) * REFQ_W'(mtpm_pkg::CENTS_PER_SEMI_Q8);
    assign deg_term = r_idx_nz ? BASE_W'(r_sc_rd) : '0;

    assign bend_term = r_apply ? SUM_W'(r_bend) : '0;
    assign sum       = SUM_W'(r_prod) + SUM_W'(r_base) + bend_term;
    always_comb begin
        if (sum > SUM_W'(PITCH_MAX)) begin
            pitch_sat = PITCH_MAX;
        end else if (sum < SUM_W'(PITCH_MIN)) begin
            pitch_sat = PITCH_MIN;
        end else begin
            pitch_sat = PW'(sum);
        end
    end

    assign out_free = !o_valid || !i_stall;

    // Table writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (sc_we) begin
            r_scale_mem[sc_wr_ext[SAW-1:0]] <= i_q_entry.wdata;
        end
        if (sc_rd_en) begin
            r_sc_rd <= r_scale_mem[sc_rd_ext[SAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[map_wr_ext[MAW-1:0]] <= i_q_entry.wdata[DW-1:0];
        end
        if (map_rd_en) begin
            r_map_rd <= r_map_mem[map_ext[MAW-1:0]];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref       <= NW'(60);
            r_force     <= 1'b1;
            r_scale_len <= 8'd0;
            r_use_map   <= 1'b0;
            r_map_len   <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mtpm_pkg::CFG_REFERENCE_NOTE: r_ref       <= i_cfg_data[NW-1:0];
                mtpm_pkg::CFG_FORCE_OCTAVE:   r_force     <= i_cfg_data[0];
                mtpm_pkg::CFG_SCALE_LEN:      r_scale_len <= i_cfg_data;
                mtpm_pkg::CFG_USE_MAPPING:    r_use_map   <= i_cfg_data[0];
                mtpm_pkg::CFG_MAP_LEN:        r_map_len   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            // In the final state the result register is reloaded instead.
            if (o_valid && !i_stall && (r_state != S_SUM)) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop && (i_q_entry.kind == mtpm_pkg::K_NOTE)) begin
                        r_channel <= i_q_entry.channel;
                        r_note    <= i_q_entry.note;
                        r_apply   <= i_q_entry.apply;
                        r_bend    <= i_q_entry.bend;
                        r_offset  <= offset;
                        r_hit     <= map_hit;
                        r_state   <= S_DEG;
                    end
                end
                S_DEG: begin
                    if (r_scale_len == 8'd0) begin
                        // Equal temperament: one semitone per degree.
                        r_oct    <= OCT_W'(degree);
                        r_period <= PERIOD_SEMI;
                        r_idx_nz <= 1'b0;
                        r_state  <= S_MUL;
                    end else begin
                        r_size  <= size_clamp;
                        r_neg   <= degree[DW-1];
                        r_quo   <= deg_mag;
                        r_rem   <= 8'd0;
                        r_cnt   <= 3'd0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 3'd0) begin
                        r_period <= r_force ? PERIOD_OCT : r_sc_rd;
                    end
                    if (div_ge) begin
                        r_rem <= 8'(div_shift - {1'b0, r_size});
                    end else begin
                        r_rem <= div_shift[7:0];
                    end
                    r_quo <= {r_quo[6:0], div_ge};
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_oct    <= fix_oct;
                    r_idx_nz <= (fix_idx != 8'd0);
                    r_state  <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= prod;
                    r_base  <= deg_term + $signed({3'b000, ref_q8});
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (out_free) begin
                        o_valid       <= 1'b1;
                        o_out_channel <= r_channel;
                        o_out_note    <= r_note;
                        o_pitch_cents <= pitch_sat;
                        o_apply_now   <= r_apply;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/microtonal_note_pitch_mapper_unit.sv
`default_nettype none

// Channel   Direction  Handshake            Beat contents
// input     in         i_valid / o_stall    action, channel, note, scale_cents, map_degree,
//                                           bend_cents
// output    out        o_valid / i_stall    out_channel, out_note, pitch_cents, apply_now
// config    in         i_cfg_we             i_cfg_index, i_cfg_data (write only)
//
// A table write is done in the back part as it leaves the queue. A note in equal
// temperament passes the degree, multiply and sum states; a loaded scale adds the
// eight-step restoring divider that finds octave and degree, and the fix state.
// Reset is synchronous and active low; it empties the queue and restores the
// configuration defaults, while the tables hold nothing defined until written.
// The two-entry queue lets the front keep taking beats while the back is busy or
// while a finished result waits in the output register; o_stall rises only when
// the queue is full.

module microtonal_note_pitch_mapper_unit #(
    parameter int SCALE_DEPTH = mtpm_pkg::SCALE_DEPTH_DEF,
    parameter int MAP_DEPTH   = mtpm_pkg::MAP_DEPTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [mtpm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [mtpm_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [mtpm_pkg::ACTION_W-1:0]         i_action,
    input  wire logic [mtpm_pkg::CHAN_W-1:0]           i_channel,
    input  wire logic [mtpm_pkg::NOTE_W-1:0]           i_note,
    input  wire logic signed [mtpm_pkg::SCALE_W-1:0]   i_scale_cents,
    input  wire logic signed [mtpm_pkg::MAPDEG_W-1:0]  i_map_degree,
    input  wire logic signed [mtpm_pkg::BEND_W-1:0]    i_bend_cents,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic [mtpm_pkg::CHAN_W-1:0]                o_out_channel,
    output logic [mtpm_pkg::NOTE_W-1:0]                o_out_note,
    output logic signed [mtpm_pkg::PITCH_W-1:0]        o_pitch_cents,
    output logic                                       o_apply_now
);

    // Front to queue: classified beats that change state or give a result.
    logic            push;
    logic            q_full;
    mtpm_pkg::t_qent push_entry;

    // Queue to back.
    logic            pop;
    logic            q_empty;
    mtpm_pkg::t_qent head_entry;

    // The front decodes the action and drops beats that have no effect, such as
    // writes past the end of a table or notes on an unserved channel.
    mtpm_front #(
        .SCALE_DEPTH (SCALE_DEPTH),
        .MAP_DEPTH   (MAP_DEPTH)
    ) u_front (
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_channel     (i_channel),
        .i_note        (i_note),
        .i_scale_cents (i_scale_cents),
        .i_map_degree  (i_map_degree),
        .i_bend_cents  (i_bend_cents),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    // Table writes go through the queue as well, so that they stay in order with
    // the notes that read the tables.
    mtpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_empty (q_empty)
    );

    // The back owns the configuration registers and both tables. It maps the key
    // to a degree, splits the degree into octave and step and reads the scale when
    // a scale is loaded, and forms the saturated pitch in the output register.
    mtpm_back #(
        .SCALE_DEPTH (SCALE_DEPTH),
        .MAP_DEPTH   (MAP_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_q_empty     (q_empty),
        .i_q_entry     (head_entry),
        .o_q_pop       (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_channel (o_out_channel),
        .o_out_note    (o_out_note),
        .o_pitch_cents (o_pitch_cents),
        .o_apply_now   (o_apply_now)
    );

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none

// Self-checking bench for the microtonal note pitch mapper. Every beat the
// block accepts is fed to a behavioral copy of the mapper that owns its own
// scale table, mapping table and register file. Tune and release beats add
// their expected tuning to an in-order list, and each tuning beat that leaves
// the block is compared against the head of that list.
module tb_top;

    localparam int ACTION_W     = mtpm_pkg::ACTION_W;
    localparam int CHAN_W       = mtpm_pkg::CHAN_W;
    localparam int NOTE_W       = mtpm_pkg::NOTE_W;
    localparam int SCALE_W      = mtpm_pkg::SCALE_W;
    localparam int MAPDEG_W     = mtpm_pkg::MAPDEG_W;
    localparam int BEND_W       = mtpm_pkg::BEND_W;
    localparam int PITCH_W      = mtpm_pkg::PITCH_W;
    localparam int CFG_IDX_W    = mtpm_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = mtpm_pkg::CFG_DATA_W;
    localparam int SCALE_DEPTH  = mtpm_pkg::SCALE_DEPTH_DEF;
    localparam int MAP_DEPTH    = mtpm_pkg::MAP_DEPTH_DEF;
    localparam int NUM_CHANNELS = mtpm_pkg::NUM_CHANNELS;
    localparam int SEMI_Q8      = mtpm_pkg::CENTS_PER_SEMI_Q8;
    localparam int OCT_Q8       = mtpm_pkg::OCTAVE_Q8;

    localparam int HALF_PERIOD   = 6;
    localparam int CYCLE_LIMIT   = 1000000;
    // A few times the worst path through the queue, the back part and the
    // output register, so table writes still in flight have landed.
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 400;
    localparam int BEND_SPAN     = 1228800;
    localparam longint PITCH_HI  = 64'sd1073741823;
    localparam longint PITCH_LO  = -64'sd1073741824;

    // Register index past the end of the register file; writes to it are dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 3'd7;

    localparam logic signed [SCALE_W-1:0]  SCALE_TOP   = {1'b0, {(SCALE_W-1){1'b1}}};
    localparam logic signed [SCALE_W-1:0]  SCALE_FLOOR = {1'b1, {(SCALE_W-1){1'b0}}};
    localparam logic signed [MAPDEG_W-1:0] DEG_TOP     = {1'b0, {(MAPDEG_W-1){1'b1}}};
    localparam logic signed [MAPDEG_W-1:0] DEG_FLOOR   = {1'b1, {(MAPDEG_W-1){1'b0}}};
    localparam logic signed [MAPDEG_W-1:0] DEG_UNMAPPED = {MAPDEG_W{1'b1}};
    localparam logic signed [BEND_W-1:0]   BEND_TOP    = {1'b0, {(BEND_W-1){1'b1}}};
    localparam logic signed [BEND_W-1:0]   BEND_FLOOR  = {1'b1, {(BEND_W-1){1'b0}}};

    // One input beat plus the idle cycles the sender spends before offering it.
    // A beat marked drain is held back until every expected tuning has arrived.
    typedef struct {
        logic [ACTION_W-1:0]         action;
        logic [CHAN_W-1:0]           channel;
        logic [NOTE_W-1:0]           note;
        logic signed [SCALE_W-1:0]   scale_cents;
        logic signed [MAPDEG_W-1:0]  map_degree;
        logic signed [BEND_W-1:0]    bend_cents;
        int                          gap;
        bit                          drain;
    } t_event;

    typedef struct {
        logic [CHAN_W-1:0]  channel;
        logic [NOTE_W-1:0]  note;
        logic [PITCH_W-1:0] pitch;
        logic               apply;
    } t_tuning;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data = '0;
    logic                         i_valid = 1'b0;
    logic                         o_stall;
    logic [ACTION_W-1:0]          i_action = '0;
    logic [CHAN_W-1:0]            i_channel = '0;
    logic [NOTE_W-1:0]            i_note = '0;
    logic signed [SCALE_W-1:0]    i_scale_cents = '0;
    logic signed [MAPDEG_W-1:0]   i_map_degree = '0;
    logic signed [BEND_W-1:0]     i_bend_cents = '0;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    logic [CHAN_W-1:0]            o_out_channel;
    logic [NOTE_W-1:0]            o_out_note;
    logic signed [PITCH_W-1:0]    o_pitch_cents;
    logic                         o_apply_now;

    always #HALF_PERIOD i_clk = ~i_clk;

    microtonal_note_pitch_mapper_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_channel     (i_channel),
        .i_note        (i_note),
        .i_scale_cents (i_scale_cents),
        .i_map_degree  (i_map_degree),
        .i_bend_cents  (i_bend_cents),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_channel (o_out_channel),
        .o_out_note    (o_out_note),
        .o_pitch_cents (o_pitch_cents),
        .o_apply_now   (o_apply_now)
    );

    // Register file and tables of the behavioral mapper, at their reset values.
    logic [NOTE_W-1:0]            tun_ref = 7'd60;
    bit                           tun_force = 1'b1;
    logic [7:0]                   tun_scale_len = 8'd0;
    bit                           tun_use_map = 1'b0;
    logic [7:0]                   tun_map_len = 8'd0;
    logic signed [SCALE_W-1:0]    scale_tbl [SCALE_DEPTH];
    logic signed [MAPDEG_W-1:0]   map_tbl [MAP_DEPTH];

    // Which table entries some queued beat has already written. The stimulus
    // only lets a note read entries that are marked here.
    bit scale_loaded [SCALE_DEPTH];
    bit map_loaded [MAP_DEPTH];

    t_event  pending [$];
    t_tuning due_tunings [$];

    t_event tx_next;
    t_event tx_now;
    bit     tx_busy = 1'b0;
    bit     tx_waiting = 1'b0;
    bit     tx_taken = 1'b0;
    bit     tx_calm = 1'b0;
    bit     rx_taken = 1'b0;
    bit     rx_calm = 1'b0;
    bit     hold_request = 1'b0;
    int     rx_left = 0;
    int     hold_left = 0;
    int     cycle_count = 0;
    int     mismatches = 0;

    // Pitch of a note under the current registers and tables. The note becomes
    // a degree through the keyboard map when its offset from the reference lies
    // inside the loaded map, then a floored divide by the scale size picks the
    // octave and the entry inside it. Equal temperament when no scale is loaded.
    function automatic logic [PITCH_W-1:0] mapped_pitch(input logic [NOTE_W-1:0] note,
                                                        input logic add_bend,
                                                        input logic signed [BEND_W-1:0] bend);
        longint offset;
        longint degree;
        longint size;
        longint octv;
        longint idx;
        longint period;
        longint step_cents;
        longint pitch;
        offset = longint'(note) - longint'(tun_ref);
        degree = offset;
        if (tun_use_map && tun_map_len != 0 && offset >= 0
            && offset < longint'(tun_map_len) && offset < MAP_DEPTH) begin
            degree = map_tbl[offset];
        end
        if (tun_scale_len == 0) begin
            pitch = (degree + longint'(tun_ref)) * SEMI_Q8;
        end else begin
            size = (longint'(tun_scale_len) > SCALE_DEPTH) ? SCALE_DEPTH
                                                           : longint'(tun_scale_len);
            octv = degree / size;
            idx = degree % size;
            if (idx < 0) begin
                idx += size;
                octv -= 1;
            end
            // Octave period is either a fixed 1200 cents or the scale's last entry.
            period = tun_force ? longint'(OCT_Q8) : longint'(scale_tbl[size - 1]);
            step_cents = (idx > 0) ? longint'(scale_tbl[idx - 1]) : 0;
            pitch = octv * period + step_cents + longint'(tun_ref) * SEMI_Q8;
        end
        if (add_bend) begin
            pitch += longint'(bend);
        end
        if (pitch > PITCH_HI) begin
            pitch = PITCH_HI;
        end
        if (pitch < PITCH_LO) begin
            pitch = PITCH_LO;
        end
        return pitch[PITCH_W-1:0];
    endfunction

    // Applies one accepted beat: table writes update the tables, tune and
    // release beats produce exactly one expected tuning.
    task automatic take_event(input t_event ev);
        t_tuning t;
        case (ev.action)
            mtpm_pkg::ACT_SCALE_WR: begin
                scale_tbl[ev.note] = ev.scale_cents;
            end
            mtpm_pkg::ACT_MAP_WR: begin
                map_tbl[ev.note] = ev.map_degree;
            end
            default: begin
                if (int'(ev.channel) < NUM_CHANNELS) begin
                    t.channel = ev.channel;
                    t.note = ev.note;
                    t.apply = (ev.action == mtpm_pkg::ACT_TUNE);
                    t.pitch = mapped_pitch(ev.note, t.apply, ev.bend_cents);
                    due_tunings.insert(due_tunings.size(), t);
                end
            end
        endcase
    endtask

    task automatic check_tuning();
        t_tuning want;
        if (due_tunings.size() == 0) begin
            $error("tuning beat with none expected: channel %0d note %0d pitch %0d",
                   o_out_channel, o_out_note, o_pitch_cents);
            mismatches++;
        end else begin
            want = due_tunings.pop_front();
            if (o_out_channel !== want.channel) begin
                $error("out_channel: expected %0d, got %0d", want.channel, o_out_channel);
                mismatches++;
            end
            if (o_out_note !== want.note) begin
                $error("out_note: expected %0d, got %0d", want.note, o_out_note);
                mismatches++;
            end
            if (o_pitch_cents !== want.pitch) begin
                $error("pitch_cents: expected %0d, got %0d",
                       $signed(want.pitch), o_pitch_cents);
                mismatches++;
            end
            if (o_apply_now !== want.apply) begin
                $error("apply_now: expected %0d, got %0d", want.apply, o_apply_now);
                mismatches++;
            end
        end
    endtask

    // Sampling side. Both handshakes are judged on the values that were set up
    // at the previous falling edge, so nothing here races the block's flops.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                take_event(tx_now);
                tx_taken = 1'b1;
            end
            if (o_valid && !i_stall) begin
                check_tuning();
                rx_taken = 1'b1;
            end
        end
    end

    // Sender. After a beat is taken the next pending one is pulled, its idle
    // gap is counted down, and only then is it offered. With a zero gap valid
    // simply stays high across the two beats. The payload only moves when a
    // new beat is loaded, so a stalled beat holds still.
    always @(negedge i_clk) begin
        if (tx_taken) begin
            tx_taken = 1'b0;
            tx_busy = 1'b0;
        end
        if (!tx_busy && !tx_waiting && pending.size() != 0) begin
            tx_next = pending.pop_front();
            tx_waiting = 1'b1;
        end
        if (tx_waiting && !(tx_next.drain && due_tunings.size() != 0)) begin
            if (tx_next.gap > 0) begin
                tx_next.gap--;
            end else begin
                tx_now = tx_next;
                tx_waiting = 1'b0;
                tx_busy = 1'b1;
            end
        end
        i_valid <= tx_busy;
        i_action <= tx_now.action;
        i_channel <= tx_now.channel;
        i_note <= tx_now.note;
        i_scale_cents <= tx_now.scale_cents;
        i_map_degree <= tx_now.map_degree;
        i_bend_cents <= tx_now.bend_cents;
    end

    // Receiver. After every taken beat it draws a fresh stall of random length. A
    // hold request overrides that with one long stall so the block's queue fills
    // and it has to stall the sender.
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (rx_taken) begin
            rx_taken = 1'b0;
            rx_left = rx_calm ? 0 : int'($urandom_range(0, 16));
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (rx_left > 0) begin
            rx_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Every field random, so bits the action ignores still toggle.
    function automatic t_event noisy_event(input logic [ACTION_W-1:0] act);
        t_event ev;
        ev.action = act;
        ev.channel = CHAN_W'($urandom());
        ev.note = NOTE_W'($urandom());
        ev.scale_cents = SCALE_W'($urandom());
        ev.map_degree = MAPDEG_W'($urandom());
        ev.bend_cents = BEND_W'($urandom());
        ev.gap = tx_calm ? 0 : int'($urandom_range(0, 16));
        ev.drain = 1'b0;
        return ev;
    endfunction

    task automatic offer(input t_event ev);
        pending.insert(pending.size(), ev);
        if (ev.action == mtpm_pkg::ACT_SCALE_WR) begin
            scale_loaded[ev.note] = 1'b1;
        end
        if (ev.action == mtpm_pkg::ACT_MAP_WR) begin
            map_loaded[ev.note] = 1'b1;
        end
    endtask

    task automatic offer_note(input logic [ACTION_W-1:0] act, input logic [CHAN_W-1:0] chan,
                              input logic [NOTE_W-1:0] note,
                              input logic signed [BEND_W-1:0] bend);
        t_event ev;
        ev = noisy_event(act);
        ev.channel = chan;
        ev.note = note;
        ev.bend_cents = bend;
        offer(ev);
    endtask

    task automatic offer_entry(input logic [ACTION_W-1:0] act, input logic [NOTE_W-1:0] idx,
                               input logic signed [SCALE_W-1:0] cents,
                               input logic signed [MAPDEG_W-1:0] degree);
        t_event ev;
        ev = noisy_event(act);
        ev.note = idx;
        ev.scale_cents = cents;
        ev.map_degree = degree;
        offer(ev);
    endtask

    // Mostly tunes and releases, with table rewrites mixed in. Half the notes
    // sit just above the reference so the keyboard map is actually consulted.
    task automatic offer_random(input int count);
        t_event ev;
        int pick;
        repeat (count) begin
            pick = int'($urandom_range(0, 99));
            if (pick < 12) begin
                ev = noisy_event(mtpm_pkg::ACT_SCALE_WR);
            end else if (pick < 22) begin
                ev = noisy_event(mtpm_pkg::ACT_MAP_WR);
            end else if (pick < 65) begin
                ev = noisy_event(mtpm_pkg::ACT_TUNE);
            end else begin
                ev = noisy_event(mtpm_pkg::ACT_RELEASE);
            end
            if ($urandom_range(0, 1) == 1) begin
                ev.note = NOTE_W'(tun_ref + $urandom_range(0, 24));
            end
            if ($urandom_range(0, 1) == 1) begin
                ev.scale_cents = SCALE_W'($urandom_range(0, OCT_Q8));
            end
            if ($urandom_range(0, 1) == 1) begin
                ev.map_degree = MAPDEG_W'(int'($urandom_range(0, 25)) - 1);
            end
            case ($urandom_range(0, 3))
                0: begin
                    ev.bend_cents = BEND_W'($urandom());
                end
                1: begin
                    ev.bend_cents = BEND_W'(int'($urandom_range(0, 2 * BEND_SPAN)) - BEND_SPAN);
                end
                2: begin
                    ev.bend_cents = BEND_W'(int'($urandom_range(0, 25600)) - 12800);
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: ev.bend_cents = BEND_TOP;
                        1: ev.bend_cents = BEND_FLOOR;
                        2: ev.bend_cents = BEND_W'(BEND_SPAN);
                        default: ev.bend_cents = BEND_W'(-BEND_SPAN);
                    endcase
                end
            endcase
            offer(ev);
        end
    endtask

    // Makes sure every entry a note can read under the current registers has
    // been written by some earlier beat.
    task automatic load_tables();
        int i;
        int limit;
        if (tun_scale_len != 0) begin
            limit = (int'(tun_scale_len) > SCALE_DEPTH) ? SCALE_DEPTH : int'(tun_scale_len);
            for (i = 0; i < limit; i++) begin
                if (!scale_loaded[i]) begin
                    offer_entry(mtpm_pkg::ACT_SCALE_WR, NOTE_W'(i),
                                SCALE_W'((i + 1) * SEMI_Q8
                                         + int'($urandom_range(0, 12800))),
                                MAPDEG_W'($urandom()));
                end
            end
        end
        if (tun_use_map && tun_map_len != 0) begin
            limit = (int'(tun_map_len) > MAP_DEPTH) ? MAP_DEPTH : int'(tun_map_len);
            for (i = 0; i < limit; i++) begin
                if (!map_loaded[i]) begin
                    offer_entry(mtpm_pkg::ACT_MAP_WR, NOTE_W'(i), SCALE_W'($urandom()),
                                MAPDEG_W'(int'($urandom_range(0, 40)) - 8));
                end
            end
        end
    endtask

    // Waits until the sender is empty and no tuning is outstanding, then
    // lets table writes that produce no beat finish in the back part.
    task automatic wait_idle();
        while (pending.size() != 0 || tx_busy || tx_waiting || due_tunings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            mtpm_pkg::CFG_REFERENCE_NOTE: tun_ref = data[NOTE_W-1:0];
            mtpm_pkg::CFG_FORCE_OCTAVE:   tun_force = data[0];
            mtpm_pkg::CFG_SCALE_LEN:      tun_scale_len = data;
            mtpm_pkg::CFG_USE_MAPPING:    tun_use_map = data[0];
            mtpm_pkg::CFG_MAP_LEN:        tun_map_len = data;
            default: ;
        endcase
    endtask

    // Rewrites the whole register file while the block is idle. Bits above a
    // narrow register's width carry noise, which the block must drop.
    task automatic reconfigure(input int ref_note, input bit force_oct, input int scale_len,
                               input bit use_map, input int map_len);
        logic [CFG_DATA_W-1:0] data;
        wait_idle();
        data = CFG_DATA_W'($urandom());
        data[NOTE_W-1:0] = NOTE_W'(ref_note);
        write_reg(mtpm_pkg::CFG_REFERENCE_NOTE, data);
        data = CFG_DATA_W'($urandom());
        data[0] = force_oct;
        write_reg(mtpm_pkg::CFG_FORCE_OCTAVE, data);
        write_reg(mtpm_pkg::CFG_SCALE_LEN, CFG_DATA_W'(scale_len));
        data = CFG_DATA_W'($urandom());
        data[0] = use_map;
        write_reg(mtpm_pkg::CFG_USE_MAPPING, data);
        write_reg(mtpm_pkg::CFG_MAP_LEN, CFG_DATA_W'(map_len));
        write_reg(CFG_SPARE_INDEX, CFG_DATA_W'($urandom()));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        load_tables();
    endtask

    task automatic random_setting(input int count);
        int ssize;
        int msize;
        ssize = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255))
                                            : int'($urandom_range(0, 16));
        msize = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255))
                                            : int'($urandom_range(0, 16));
        reconfigure(int'($urandom_range(0, 127)), bit'($urandom_range(0, 1)), ssize,
                    bit'($urandom_range(0, 1)), msize);
        offer_random(count);
    endtask

    initial begin
        t_event ev;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: equal temperament around note 60. Note and bend
        // extremes first, then the first table entries and the last ones.
        offer_note(mtpm_pkg::ACT_TUNE, 4'd0, 7'd0, BEND_FLOOR);
        offer_note(mtpm_pkg::ACT_TUNE, 4'd15, 7'd127, BEND_TOP);
        offer_note(mtpm_pkg::ACT_RELEASE, 4'd7, 7'd60, BEND_TOP);
        offer_note(mtpm_pkg::ACT_TUNE, 4'd1, 7'd60, BEND_W'(BEND_SPAN));
        offer_note(mtpm_pkg::ACT_TUNE, 4'd2, 7'd61, BEND_W'(-BEND_SPAN));
        offer_note(mtpm_pkg::ACT_TUNE, 4'd9, 7'd127, '0);
        offer_entry(mtpm_pkg::ACT_SCALE_WR, 7'd0, SCALE_TOP, DEG_FLOOR);
        offer_entry(mtpm_pkg::ACT_SCALE_WR, 7'd127, SCALE_FLOOR, DEG_TOP);
        offer_entry(mtpm_pkg::ACT_MAP_WR, 7'd0, SCALE_FLOOR, DEG_FLOOR);
        offer_entry(mtpm_pkg::ACT_MAP_WR, 7'd127, SCALE_TOP, DEG_TOP);
        offer_note(mtpm_pkg::ACT_RELEASE, 4'd15, 7'd0, BEND_FLOOR);
        offer_random(90);

        // One-degree scale whose period is its only entry, with a mapped
        // degree of -128: the pitch overruns the output range both ways.
        reconfigure(0, 1'b0, 1, 1'b1, 1);
        offer_entry(mtpm_pkg::ACT_SCALE_WR, 7'd0, SCALE_FLOOR, DEG_TOP);
        offer_entry(mtpm_pkg::ACT_MAP_WR, 7'd0, SCALE_TOP, DEG_FLOOR);
        offer_note(mtpm_pkg::ACT_TUNE, 4'd3, 7'd0, BEND_TOP);
        offer_entry(mtpm_pkg::ACT_SCALE_WR, 7'd0, SCALE_TOP, DEG_TOP);
        offer_note(mtpm_pkg::ACT_TUNE, 4'd4, 7'd0, BEND_FLOOR);
        // A map entry of all ones is taken as the degree -1, like any other.
        offer_entry(mtpm_pkg::ACT_MAP_WR, 7'd0, SCALE_TOP, DEG_UNMAPPED);
        offer_note(mtpm_pkg::ACT_TUNE, 4'd5, 7'd0, '0);
        offer_note(mtpm_pkg::ACT_RELEASE, 4'd6, 7'd1, BEND_TOP);
        offer_note(mtpm_pkg::ACT_RELEASE, 4'd8, 7'd127, BEND_FLOOR);
        offer_random(60);

        // Twelve-note scale with a twelve-key map. Halfway through, the sender
        // waits until every expected tuning has come back.
        reconfigure(60, 1'b0, 12, 1'b1, 12);
        offer_random(60);
        ev = noisy_event(mtpm_pkg::ACT_TUNE);
        ev.drain = 1'b1;
        offer(ev);
        offer_random(60);

        // Largest legal sizes, and sizes past the table depth.
        reconfigure(127, 1'b1, 128, 1'b1, 128);
        offer_random(100);
        reconfigure(0, 1'b1, 200, 1'b1, 255);
        offer_random(100);

        // Long receiver hold while the sender pushes beats back to back.
        reconfigure(69, 1'b0, 7, 1'b0, 0);
        tx_calm = 1'b1;
        @(posedge i_clk);
        hold_request = 1'b1;
        offer_random(60);
        tx_calm = 1'b0;
        offer_random(60);

        // Map enabled but empty, so it is ignored; neither side idles here.
        reconfigure(30, 1'b1, 0, 1'b1, 0);
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        offer_random(80);

        reconfigure(64, 1'b0, 255, 1'b0, 5);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        offer_random(100);

        random_setting(80);
        random_setting(80);

        wait_idle();
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
